// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define CTT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ctt assertion failed");

// clocked check that also holds during reset
`define CTT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ctt assertion failed");

`endif

// File: rtl/core/ctt_pkg.sv
package ctt_pkg;

  // raw opcodes on the command port
  localparam logic [1:0] OPC_INSERT     = 2'd0;
  localparam logic [1:0] OPC_REMOVE     = 2'd1;
  localparam logic [1:0] OPC_LOOKUP     = 2'd2;
  localparam logic [1:0] OPC_PORT_QUERY = 2'd3;

  // command queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_LOOKUP     = 2'd2,
    OP_PORT_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISS    = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } key_t;

  // one table entry as stored in the data ram
  typedef struct packed {
    key_t        key;
    logic [15:0] handle;
  } ent_t;

  // classified command
  typedef struct packed {
    op_e         op;
    key_t        key;
    logic [15:0] handle;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [15:0] handle;
    status_e     status;
  } res_t;

  // queue side of the front/back link
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_head_t;

  // back engine status seen by the front
  typedef struct packed {
    logic clearing;
  } bk_stat_t;

endpackage

// File: rtl/core/ctt_ram.sv
module ctt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ctt_front.sv
module ctt_front import ctt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [15:0] conn_handle_i,
  input  bk_stat_t    bk_stat_i,
  input  logic        pop_i,
  output q_head_t     head_o,
  output logic        busy_o
);

  cmd_t             cmd;
  op_e              op;
  logic             push;
  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  // classify the opcode
  always_comb begin
    unique case (opcode_i)
      OPC_INSERT:     op = OP_INSERT;
      OPC_REMOVE:     op = OP_REMOVE;
      OPC_LOOKUP:     op = OP_LOOKUP;
      OPC_PORT_QUERY: op = OP_PORT_QUERY;
    endcase
  end

  assign cmd.op           = op;
  assign cmd.key.src_addr = src_addr_i;
  assign cmd.key.dst_addr = dst_addr_i;
  assign cmd.key.src_port = src_port_i;
  assign cmd.key.dst_port = dst_port_i;
  assign cmd.handle       = conn_handle_i;

  assign busy_o = bk_stat_i.clearing || (cnt_q == QCntW'(QDepth));
  assign push   = start_i && !busy_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd;
    end
  end

  assign head_o.vld = (cnt_q != '0);
  assign head_o.cmd = mem_q[rptr_q];

endmodule

// File: rtl/core/ctt_back.sv
module ctt_back import ctt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_head_t  head_i,
  output logic     pop_o,
  output bk_stat_t stat_o,
  output logic     done_o,
  output res_t     res_o
);

  localparam int unsigned AW   = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] Last = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] chk_idx_q, chk_idx_d;
  logic          chk_vld_q, chk_vld_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  logic [15:0]   hit_handle_q, hit_handle_d;
  logic          free_seen_q, free_seen_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  cmd_t          cur_q, cur_d;
  res_t          res_q, res_d;
  logic          done_q, done_d;

  logic          v_we, v_wdata, v_rdata;
  logic          d_we;
  logic [AW-1:0] w_addr;
  ent_t          d_wdata, d_rdata;
  logic          key_match, port_match, scan_hit;

  ctt_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_ENTRIES)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (w_addr),
    .wdata_i (v_wdata),
    .raddr_i (ptr_q),
    .rdata_o (v_rdata)
  );

  ctt_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (w_addr),
    .wdata_i (d_wdata),
    .raddr_i (ptr_q),
    .rdata_o (d_rdata)
  );

  assign key_match  = v_rdata && (d_rdata.key == cur_q.key);
  assign port_match = v_rdata && (d_rdata.key.src_port == cur_q.key.src_port);
  assign scan_hit   = chk_vld_q && ((cur_q.op == OP_PORT_QUERY) ? port_match : key_match);

  assign d_wdata.key    = cur_q.key;
  assign d_wdata.handle = cur_q.handle;

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    ptr_d        = ptr_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = chk_vld_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_handle_d = hit_handle_q;
    free_seen_d  = free_seen_q;
    free_idx_d   = free_idx_q;
    cur_d        = cur_q;
    res_d        = res_q;
    done_d       = 1'b0;
    pop_o        = 1'b0;
    v_we         = 1'b0;
    v_wdata      = 1'b0;
    d_we         = 1'b0;
    w_addr       = hit_idx_q;

    unique case (state_q)
      S_CLEAR: begin
        v_we   = 1'b1;
        w_addr = clr_cnt_q;
        if (clr_cnt_q == Last) begin
          state_d = S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (head_i.vld) begin
          pop_o       = 1'b1;
          cur_d       = head_i.cmd;
          ptr_d       = '0;
          chk_vld_d   = 1'b0;
          hit_d       = 1'b0;
          free_seen_d = 1'b0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        // ram read data is registered, so it trails the read pointer
        chk_vld_d = 1'b1;
        chk_idx_d = ptr_q;
        if (ptr_q != Last) begin
          ptr_d = ptr_q + AW'(1);
        end
        if (chk_vld_q && !v_rdata && !free_seen_q) begin
          free_seen_d = 1'b1;
          free_idx_d  = chk_idx_q;
        end
        if (scan_hit) begin
          hit_d        = 1'b1;
          hit_idx_d    = chk_idx_q;
          hit_handle_d = d_rdata.handle;
          chk_vld_d    = 1'b0;
          state_d      = S_EXEC;
        end else if (chk_vld_q && (chk_idx_q == Last)) begin
          chk_vld_d = 1'b0;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        done_d       = 1'b1;
        res_d.found  = hit_q;
        res_d.handle = '0;
        res_d.status = ST_DONE;
        unique case (cur_q.op)
          OP_INSERT: begin
            if (hit_q) begin
              res_d.status = ST_PRESENT;
            end else if (free_seen_q) begin
              v_we    = 1'b1;
              v_wdata = 1'b1;
              d_we    = 1'b1;
              w_addr  = free_idx_q;
            end else begin
              res_d.status = ST_FULL;
            end
          end
          OP_REMOVE: begin
            if (hit_q && (hit_handle_q == cur_q.handle)) begin
              v_we = 1'b1;
            end else begin
              res_d.status = ST_MISS;
            end
          end
          OP_LOOKUP: begin
            if (hit_q) begin
              res_d.handle = hit_handle_q;
            end else begin
              res_d.status = ST_MISS;
            end
          end
          OP_PORT_QUERY: begin
            if (!hit_q) begin
              res_d.status = ST_MISS;
            end
          end
        endcase
        ptr_d   = '0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      ptr_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_seen_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      ptr_q       <= ptr_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      free_seen_q <= free_seen_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    hit_idx_q    <= hit_idx_d;
    hit_handle_q <= hit_handle_d;
    free_idx_q   <= free_idx_d;
    cur_q        <= cur_d;
    res_q        <= res_d;
  end

  assign stat_o.clearing = (state_q == S_CLEAR);
  assign done_o          = done_q;
  assign res_o           = res_q;

endmodule

// File: rtl/core/connection_tuple_table_unit.sv
// channel   | handshake          | beat contents
// ----------+--------------------+---------------------------------------------------
// command   | start_i / busy_o   | opcode, src/dst addr, src/dst port, conn_handle
// result    | done_o (strobe)    | found, result_handle, status
//
// the back pops one command from the queue, scans the entries from index 0 up to the
// matching entry or the last one, then executes the op and raises the registered
// result strobe; it takes no new command from the queue until that command is done
// a miss, an insert of a new key or a full-table insert scans all TABLE_ENTRIES
// entries, set by the one-entry-per-cycle scan through the single read port of the rams
// after reset a clearing pass over all TABLE_ENTRIES entries zeroes the valid ram, busy_o
// stays high meanwhile
// a two-beat command queue keeps accepting while the scan engine works; busy_o rises
// when it is full or during clearing, and results cannot be held off by the receiver
`include "assert_macros.svh"

module connection_tuple_table_unit import ctt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command beat
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [15:0] conn_handle_i,
  // result beat
  output logic        done_o,
  output logic        found_o,
  output logic [15:0] result_handle_o,
  output logic [1:0]  status_o
);

  // front to back: queue head, pop back; back status gates acceptance
  q_head_t  q_head;
  logic     q_pop;
  bk_stat_t bk_stat;
  res_t     res;

  // front: classify the opcode, build the key and queue the command
  ctt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .opcode_i      (opcode_i),
    .src_addr_i    (src_addr_i),
    .dst_addr_i    (dst_addr_i),
    .src_port_i    (src_port_i),
    .dst_port_i    (dst_port_i),
    .conn_handle_i (conn_handle_i),
    .bk_stat_i     (bk_stat),
    .pop_i         (q_pop),
    .head_o        (q_head),
    .busy_o        (busy_o)
  );

  // back: scan the table rams, then write back where the op calls for it and report one result
  ctt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .stat_o (bk_stat),
    .done_o (done_o),
    .res_o  (res)
  );

  // result fields come straight from the back's output registers
  assign found_o         = res.found;
  assign result_handle_o = res.handle;
  assign status_o        = res.status;

  // every result is a single-cycle strobe
  `CTT_ASSERT(a_done_single, done_o |=> !done_o)
  // the back never pops an empty queue
  `CTT_ASSERT(a_pop_nonempty, q_pop |-> q_head.vld)
  // no result while the valid ram is being cleared
  `CTT_ASSERT(a_no_done_clear, bk_stat.clearing |-> !done_o)

endmodule
